### hw/rtl/eec_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_pkg
// Types, constants and helper functions shared by the exponential easing
// curve core: fixed-point scaling, curve and post-processing codes, and the
// 2^-f table generator.
// ----------------------------------------------------------------------------
package eec_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned PROG_W    = FRAC_BITS + 1;
	localparam int unsigned EASED_W   = FRAC_BITS + 2;
	// Exponent argument reaches a little over 10.0.
	localparam int unsigned EXP_W     = FRAC_BITS + 4;
	localparam int unsigned SHIFT_W   = 4;
	localparam int unsigned ROM_W     = 31;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 8;

	localparam int unsigned ONE_FX = 1 << FRAC_BITS;
	localparam int unsigned C1     = (ONE_FX + 500) / 1000;
	localparam int unsigned C2     = (ONE_FX + 1000) / 2000;

	// q / 1000 == (q * RECIP) >> 26 and q / 2000 == (q * RECIP) >> 27 for
	// every operand this core can produce.
	localparam int unsigned DIV_SHIFT = 26;
	localparam int unsigned RECIP     = ((1 << DIV_SHIFT) + 999) / 1000;
	localparam int unsigned RECIP_W   = 17;
	localparam int unsigned DIVX_W    = 17;
	localparam int unsigned DIVP_W    = DIVX_W + RECIP_W;
	localparam int unsigned QUOT_W    = 8;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned LN2_Q30 = 64'd744261118;
	localparam int unsigned SERIES_TERMS = 20;

	typedef logic [PROG_W-1:0]         progress_t;
	typedef logic signed [EASED_W-1:0] eased_t;
	typedef logic [EXP_W-1:0]          exp_arg_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]     cfg_data_t;

	localparam progress_t PROG_ONE  = progress_t'(ONE_FX);
	localparam progress_t PROG_HALF = progress_t'(ONE_FX >> 1);

	localparam cfg_idx_t CFG_CURVE_MODE    = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_EASING_ENABLE = cfg_idx_t'(1);

	typedef enum logic [1:0] {
		MODE_IN     = 2'd0,
		MODE_OUT    = 2'd1,
		MODE_IN_OUT = 2'd2,
		MODE_OUT_IN = 2'd3
	} curve_mode_t;

	// What the last stages do with the power-of-two value P.
	typedef enum logic [2:0] {
		POST_DIRECT   = 3'd0,
		POST_SUB_C2   = 3'd1,
		POST_OUT_1000 = 3'd2,
		POST_OUT_2000 = 3'd3,
		POST_OUTIN_LO = 3'd4,
		POST_OUTIN_HI = 3'd5,
		POST_CONST    = 3'd6
	} post_kind_t;

	typedef struct packed {
		post_kind_t kind;
		progress_t  cval;
	} item_ctl_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} stage_en_t;

	function automatic exp_arg_t times10(input progress_t x);
		return (exp_arg_t'(x) << 3) + (exp_arg_t'(x) << 1);
	endfunction

	// Unsigned quotient by shift and subtract, for building constant tables.
	function automatic longint unsigned const_udiv(input longint unsigned num,
			input longint unsigned den);
		longint unsigned rem;
		longint unsigned quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			quo = quo << 1;
			if (rem >= den) begin
				rem    = rem - den;
				quo[0] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Sample j of 2^-(j/entries) in Q1.30 from a truncated series of
	// e^-(f ln2). Used only to build constant tables.
	function automatic logic [ROM_W-1:0] exp_rom_entry(input int unsigned j,
			input int unsigned entries);
		longint unsigned y;
		longint unsigned term;
		longint          sum;
		int unsigned     n;
		if (j >= entries) begin
			return ROM_W'(Q30_ONE >> 1);
		end
		y    = const_udiv(longint'(j) * LN2_Q30, longint'(entries));
		term = Q30_ONE;
		sum  = longint'(Q30_ONE);
		for (n = 1; n <= SERIES_TERMS; n++) begin
			term = const_udiv((term * y) >> 30, longint'(n));
			if ((n & 1) != 0) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(Q30_ONE)) begin
			sum = longint'(Q30_ONE);
		end
		return ROM_W'(sum);
	endfunction

endpackage
`default_nettype wire

### hw/rtl/eec_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_if
// Valid/ready channels of the easing core: progress input, eased output and
// the register write port.
// ----------------------------------------------------------------------------
interface eec_in_if;
	import eec_pkg::*;
	logic      valid;
	logic      ready;
	progress_t progress;
	modport source (output valid, output progress, input ready);
	modport sink (input valid, input progress, output ready);
endinterface

interface eec_out_if;
	import eec_pkg::*;
	logic   valid;
	logic   ready;
	eased_t eased_value;
	modport source (output valid, output eased_value, input ready);
	modport sink (input valid, input eased_value, output ready);
endinterface

interface eec_cfg_if;
	import eec_pkg::*;
	logic      valid;
	logic      ready;
	cfg_idx_t  index;
	cfg_data_t data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/eec_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_decode
// Stage 1: clamps progress, picks the curve branch and forms the exponent
// argument, the extra halving and the post-processing code.
// ----------------------------------------------------------------------------
module eec_decode (
	input  wire                  clk,
	input  wire                  en,
	input  eec_pkg::progress_t   progress,
	input  eec_pkg::curve_mode_t mode,
	input  wire                  easing_enable,
	output eec_pkg::exp_arg_t    e_s1,
	output logic                 extra_s1,
	output eec_pkg::item_ctl_t   ctl_s1
);
	import eec_pkg::*;

	progress_t           tc;
	logic [PROG_W:0]     u;
	progress_t           w;
	exp_arg_t            e_d;
	logic                extra_d;
	item_ctl_t           ctl_d;

	localparam logic [PROG_W:0] U_ONE = (PROG_W + 1)'(ONE_FX);

	always_comb begin
		tc = (progress > PROG_ONE) ? PROG_ONE : progress;
		u  = {tc, 1'b0};
		w  = progress_t'(u - U_ONE);
		e_d        = '0;
		extra_d    = 1'b0;
		ctl_d.kind = POST_CONST;
		ctl_d.cval = tc;
		if (easing_enable) begin
			unique case (mode)
				MODE_IN: begin
					if (tc != '0 && tc != PROG_ONE) begin
						e_d        = times10(PROG_ONE - tc) + exp_arg_t'(C1);
						ctl_d.kind = POST_DIRECT;
					end
				end
				MODE_OUT: begin
					if (tc != PROG_ONE) begin
						e_d        = times10(tc);
						ctl_d.kind = POST_OUT_1000;
					end
				end
				MODE_IN_OUT: begin
					if (tc != '0 && tc != PROG_ONE) begin
						extra_d = 1'b1;
						if (u < U_ONE) begin
							e_d        = times10(PROG_ONE - u[PROG_W-1:0]);
							ctl_d.kind = POST_SUB_C2;
						end else begin
							e_d        = times10(w);
							ctl_d.kind = POST_OUT_2000;
						end
					end
				end
				MODE_OUT_IN: begin
					if (u < U_ONE) begin
						e_d        = times10(u[PROG_W-1:0]);
						ctl_d.kind = POST_OUTIN_LO;
					end else if (w == '0) begin
						ctl_d.cval = PROG_HALF;
					end else if (w == PROG_ONE) begin
						ctl_d.cval = PROG_ONE;
					end else begin
						e_d        = times10(PROG_ONE - w) + exp_arg_t'(C1);
						ctl_d.kind = POST_OUTIN_HI;
					end
				end
				default: begin
					ctl_d.kind = POST_CONST;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s1     <= e_d;
			extra_s1 <= extra_d;
			ctl_s1   <= ctl_d;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/eec_exp2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_exp2
// Stages 2 to 4: round(ONE * 2^(-e/ONE) / 2^extra). Table lookup of 2^-f,
// linear interpolation, then a rounding right shift by the integer part.
// ----------------------------------------------------------------------------
module eec_exp2 #(
	parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
	input  wire                 clk,
	input  eec_pkg::stage_en_t  en,
	input  eec_pkg::exp_arg_t   e_s1,
	input  wire                 extra_s1,
	input  eec_pkg::item_ctl_t  ctl_s1,
	output eec_pkg::progress_t  p_s4,
	output eec_pkg::item_ctl_t  ctl_s4
);
	import eec_pkg::*;

	localparam int unsigned IW  = $clog2(EXP_TABLE_ENTRIES + 1);
	localparam int unsigned PW  = FRAC_BITS + IW;
	localparam int unsigned MW  = ROM_W + FRAC_BITS;
	localparam int unsigned SW  = 5;
	localparam logic [IW-1:0] IDX_LAST = IW'(EXP_TABLE_ENTRIES - 1);

	logic [ROM_W-1:0] rom_w [0:EXP_TABLE_ENTRIES];

	for (genvar j = 0; j <= EXP_TABLE_ENTRIES; j++) begin : g_rom
		localparam logic [ROM_W-1:0] ROM_VAL = exp_rom_entry(j, EXP_TABLE_ENTRIES);
		assign rom_w[j] = ROM_VAL;
	end

	// Stage 2: split the argument and read the two neighboring samples.
	logic [SHIFT_W-1:0]   k;
	logic [PW-1:0]        pos;
	logic [IW-1:0]        idx_raw;
	logic [IW-1:0]        idx;
	logic [ROM_W-1:0]     a_s2, b_s2;
	logic [FRAC_BITS-1:0] rem_s2;
	logic [SHIFT_W-1:0]   k_s2;
	logic                 extra_s2;
	item_ctl_t            ctl_s2;

	always_comb begin
		k       = e_s1[EXP_W-1:FRAC_BITS];
		pos     = PW'(e_s1[FRAC_BITS-1:0]) * PW'(EXP_TABLE_ENTRIES);
		idx_raw = pos[PW-1:FRAC_BITS];
		idx     = (idx_raw > IDX_LAST) ? IDX_LAST : idx_raw;
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			a_s2     <= rom_w[idx];
			b_s2     <= rom_w[IW'(idx + 1'b1)];
			rem_s2   <= pos[FRAC_BITS-1:0];
			k_s2     <= k;
			extra_s2 <= extra_s1;
			ctl_s2   <= ctl_s1;
		end
	end

	// Stage 3: slope times remainder.
	logic [ROM_W-1:0]     diff;
	logic                 dec;
	logic [MW-1:0]        prod_s3;
	logic [ROM_W-1:0]     a_s3;
	logic                 dec_s3;
	logic [SHIFT_W-1:0]   k_s3;
	logic                 extra_s3;
	item_ctl_t            ctl_s3;

	always_comb begin
		dec  = (a_s2 >= b_s2);
		diff = dec ? (a_s2 - b_s2) : (b_s2 - a_s2);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			prod_s3  <= MW'(diff) * MW'(rem_s2);
			a_s3     <= a_s2;
			dec_s3   <= dec;
			k_s3     <= k_s2;
			extra_s3 <= extra_s2;
			ctl_s3   <= ctl_s2;
		end
	end

	// Stage 4: interpolate, then shift right with round half up.
	logic [ROM_W:0] v;
	logic [ROM_W:0] half;
	logic [ROM_W:0] rnd;
	logic [SW-1:0]  s;

	always_comb begin
		if (dec_s3) begin
			v = {1'b0, a_s3} - {1'b0, prod_s3[MW-1:FRAC_BITS]};
		end else begin
			v = {1'b0, a_s3} + {1'b0, prod_s3[MW-1:FRAC_BITS]};
		end
		s    = SW'(k_s3) + SW'(30 - FRAC_BITS) + SW'(extra_s3);
		half = (ROM_W + 1)'(1) << (s - 1'b1);
		rnd  = (v + half) >> s;
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			p_s4   <= rnd[PROG_W-1:0];
			ctl_s4 <= ctl_s3;
		end
	end

endmodule
`default_nettype wire

### hw/rtl/eec_finish.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_finish
// Stages 5 and 6: the small overshoot term by reciprocal multiplication,
// then the branch-specific combination into the signed Q1.16 result.
// ----------------------------------------------------------------------------
module eec_finish (
	input  wire                 clk,
	input  eec_pkg::stage_en_t  en,
	input  eec_pkg::progress_t  p_s4,
	input  eec_pkg::item_ctl_t  ctl_s4,
	output eec_pkg::eased_t     res_s6
);
	import eec_pkg::*;

	// Stage 5: q = ONE - P and the scaled q + bias product.
	progress_t         q;
	logic [DIVX_W-1:0] x;
	logic [DIVP_W-1:0] dprod_s5;
	progress_t         q_s5;
	progress_t         p_s5;
	item_ctl_t         ctl_s5;

	always_comb begin
		q = PROG_ONE - p_s4;
		if (ctl_s4.kind == POST_OUT_2000) begin
			x = DIVX_W'(q) + DIVX_W'(1000);
		end else begin
			x = DIVX_W'(q) + DIVX_W'(500);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			dprod_s5 <= DIVP_W'(x) * DIVP_W'(RECIP);
			q_s5     <= q;
			p_s5     <= p_s4;
			ctl_s5   <= ctl_s4;
		end
	end

	// Stage 6: combine.
	logic [QUOT_W-1:0]  quot;
	logic [EASED_W-1:0] qsum;
	logic [EASED_W-1:0] r;

	always_comb begin
		if (ctl_s5.kind == POST_OUT_2000) begin
			quot = QUOT_W'(dprod_s5 >> (DIV_SHIFT + 1));
		end else begin
			quot = QUOT_W'(dprod_s5 >> DIV_SHIFT);
		end
		qsum = EASED_W'(q_s5) + EASED_W'(quot);
		case (ctl_s5.kind)
			POST_DIRECT:   r = EASED_W'(p_s5);
			POST_SUB_C2:   r = EASED_W'(p_s5) - EASED_W'(C2);
			POST_OUT_1000: r = qsum;
			POST_OUT_2000: r = qsum;
			POST_OUTIN_LO: r = (qsum + 1'b1) >> 1;
			POST_OUTIN_HI: r = ((EASED_W'(p_s5) + 1'b1) >> 1) + EASED_W'(PROG_HALF);
			POST_CONST:    r = EASED_W'(ctl_s5.cval);
			default:       r = EASED_W'(ctl_s5.cval);
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			res_s6 <= eased_t'(r);
		end
	end

endmodule
`default_nettype wire

### hw/rtl/exponential_easing_curve_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exponential_easing_curve_core
// Pipeline: an accepted progress beat moves through stages s1 to s6 to become its eased beat.
// Throughput: one beat per cycle; the six-stage pipeline with a valid bit
// per stage takes a new beat whenever stage 1 is empty or moves on.
// Reset: clears all stage valid bits, curve_mode to ease in and
// easing_enable to 1. The 2^-f table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module exponential_easing_curve_core #(
	parameter int unsigned EXP_TABLE_ENTRIES = 64
) (
	input  wire     clk,
	input  wire     arst_n,
	eec_in_if.sink  prog,
	eec_out_if.source eased,
	eec_cfg_if.sink cfg
);
	import eec_pkg::*;

	curve_mode_t mode_q;
	logic        enable_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IN;
			enable_q <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_CURVE_MODE:    mode_q   <= curve_mode_t'(cfg.data[1:0]);
				CFG_EASING_ENABLE: enable_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or the stage after it loads.
	logic      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	stage_en_t en;

	always_comb begin
		en.s6 = !v_s6 || eased.ready;
		en.s5 = !v_s5 || en.s6;
		en.s4 = !v_s4 || en.s5;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en.s1 = !v_s1 || en.s2;
	end

	assign prog.ready  = en.s1;
	assign eased.valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en.s1) v_s1 <= prog.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
			if (en.s5) v_s5 <= v_s4;
			if (en.s6) v_s6 <= v_s5;
		end
	end

	exp_arg_t  e_s1;
	logic      extra_s1;
	item_ctl_t ctl_s1;
	progress_t p_s4;
	item_ctl_t ctl_s4;
	eased_t    res_s6;

	eec_decode u_decode (
		.clk           (clk),
		.en            (en.s1),
		.progress      (prog.progress),
		.mode          (mode_q),
		.easing_enable (enable_q),
		.e_s1          (e_s1),
		.extra_s1      (extra_s1),
		.ctl_s1        (ctl_s1)
	);

	eec_exp2 #(
		.EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
	) u_exp2 (
		.clk      (clk),
		.en       (en),
		.e_s1     (e_s1),
		.extra_s1 (extra_s1),
		.ctl_s1   (ctl_s1),
		.p_s4     (p_s4),
		.ctl_s4   (ctl_s4)
	);

	eec_finish u_finish (
		.clk    (clk),
		.en     (en),
		.p_s4   (p_s4),
		.ctl_s4 (ctl_s4),
		.res_s6 (res_s6)
	);

	assign eased.eased_value = res_s6;

endmodule
`default_nettype wire

### hw/rtl/eec_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eec_checker
// Port-level checks of the easing core, bound to the top level.
// ----------------------------------------------------------------------------
module eec_checker (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input eec_pkg::eased_t      out_value
);
	import eec_pkg::*;

	// Reset empties the pipeline at once.
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output beat present during reset");

	// With the output free, no stage can hold back, so input is taken.
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while the output side is free");

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
		else $error("stalled output beat changed");

	// Curves stay within a small undershoot and overshoot around 0 and 1.0.
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_value >= -18'sd33) && (out_value <= 18'sd65602)))
		else $error("eased value outside curve range");

	// After an accepted input beat, output valid must not be unknown.
	a_in_valid_known: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !$isunknown(out_valid))
		else $error("output valid unknown after an input beat");

endmodule

bind exponential_easing_curve_core eec_checker u_eec_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (prog.valid),
	.in_ready  (prog.ready),
	.out_valid (eased.valid),
	.out_ready (eased.ready),
	.out_value (eased.eased_value)
);
`default_nettype wire
